>>> rtl/apbi_pkg.sv
`timescale 1ns / 1ps
package apbi_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int GROUP_COUNT = 64;

  localparam int TIME_W  = 40;
  localparam int DUR_W   = 32;
  localparam int AGE_W   = 16;
  localparam int PRI_W   = 8;
  localparam int GID_W   = 6;
  localparam int POS_W   = 7;
  localparam int STEP_W  = 8;
  localparam int QADDR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int GADDR_W = $clog2(GROUP_COUNT);
  localparam int GIDS    = 1 << GID_W;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [AGE_W-1:0]  AGE_MAX  = '1;

  localparam logic STATUS_INSERTED = 1'b0;
  localparam logic STATUS_FULL     = 1'b1;

  // one stored job
  typedef struct packed {
    logic [TIME_W-1:0]  end_time;
    logic [AGE_W-1:0]   age;
    logic [PRI_W-1:0]   priority_lvl;
    logic [GADDR_W-1:0] grp;
  } entry_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_OWN,
    S_ERD,
    S_GRD,
    S_FIN,
    S_SWR,
    S_INS,
    S_OUT
  } state_t;

  typedef logic [GADDR_W-1:0] grp_map_t [GIDS];

  // group id folded onto the group table, worked out at elaboration
  function automatic grp_map_t build_grp_map();
    grp_map_t m;
    for (int i = 0; i < GIDS; i++) begin
      m[i] = GADDR_W'(i % GROUP_COUNT);
    end
    return m;
  endfunction

  localparam grp_map_t GRP_MAP = build_grp_map();

endpackage

>>> rtl/apbi_if.sv
`timescale 1ns / 1ps
interface apbi_in_if;
  logic                       valid;
  logic                       ready;
  logic [apbi_pkg::PRI_W-1:0] task_priority;
  logic [apbi_pkg::DUR_W-1:0] task_duration;
  logic [apbi_pkg::GID_W-1:0] group_id;

  modport source (output valid, task_priority, task_duration, group_id, input ready);
  modport sink (input valid, task_priority, task_duration, group_id, output ready);
endinterface

interface apbi_out_if;
  logic                        valid;
  logic                        ready;
  logic [apbi_pkg::POS_W-1:0]  insert_position;
  logic [apbi_pkg::TIME_W-1:0] task_end;
  logic                        status;

  modport source (output valid, insert_position, task_end, status, input ready);
  modport sink (input valid, insert_position, task_end, status, output ready);
endinterface

>>> rtl/apbi_ram.sv
`timescale 1ns / 1ps
module apbi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/aged_priority_backfill_insert_top.sv
`timescale 1ns / 1ps
// Backfilling insertion into an aged-priority job queue. Each request walks
// the stored queue from its tail, entry by entry (entry read with
// group-end read, then compare and update through the shared update unit),
// then shifts later entries back one per cycle and writes the new entry.
// A request holds the block until its result is taken, and no new request
// is taken before then. A full queue goes straight from idle to the result
// state. After reset all GROUP_COUNT (64) entries of the group-end table
// are cleared before the first request is taken; configuration writes are
// taken at any time.
module aged_priority_backfill_insert_top (
  input  logic                       clk,
  input  logic                       rst,
  apbi_in_if.sink                    in,
  apbi_out_if.source                 out,
  input  logic                       age_step_we,
  input  logic [apbi_pkg::STEP_W-1:0] age_step_wdata
);
  import apbi_pkg::*;

  state_t state, state_next;
  logic [GADDR_W-1:0] clr_idx, clr_idx_next;
  logic [CNT_W-1:0]   k, k_next, pos, pos_next, count, count_next;
  logic [PRI_W-1:0]   pri, pri_next;
  logic [DUR_W-1:0]   dur, dur_next;
  logic [GADDR_W-1:0] grp, grp_next;
  logic [TIME_W-1:0]  own_ge, own_ge_next, new_end, new_end_next;
  entry_t             ent, ent_next;
  logic [STEP_W-1:0]  age_step;
  logic [POS_W-1:0]   o_pos, o_pos_next;
  logic [TIME_W-1:0]  o_end, o_end_next;
  logic               o_status, o_status_next;

  logic               e_we, g_we;
  logic [QADDR_W-1:0] e_waddr, e_raddr;
  entry_t             e_wdata, e_rdata;
  logic [GADDR_W-1:0] g_waddr, g_raddr;
  logic [TIME_W-1:0]  g_wdata, g_rdata;

  logic [TIME_W:0]    sum;
  logic [TIME_W-1:0]  upd;
  logic [AGE_W:0]     age_sum;
  logic [AGE_W-1:0]   age_upd;
  logic [PRI_W+AGE_W-2:0] eff;
  logic               skip_hi, skip_eq;
  logic [CNT_W-1:0]   km1, km2;

  apbi_ram #(.WIDTH($bits(entry_t)), .DEPTH(QUEUE_DEPTH)) u_entry_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  apbi_ram #(.WIDTH(TIME_W), .DEPTH(GROUP_COUNT)) u_group_ram (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(g_raddr), .rdata(g_rdata)
  );

  // shared update unit: saturating end time, aged entry, compares
  always_comb begin
    sum     = {1'b0, ent.end_time} + {{(TIME_W + 1 - DUR_W){1'b0}}, dur};
    upd     = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    age_sum = {1'b0, ent.age} + {{(AGE_W + 1 - STEP_W){1'b0}}, age_step};
    age_upd = age_sum[AGE_W] ? AGE_MAX : age_sum[AGE_W-1:0];
    eff     = {{(AGE_W - 2){1'b0}}, ent.priority_lvl}
              + {{PRI_W{1'b0}}, ent.age[AGE_W-1:2]};
    skip_hi = {{(AGE_W - 2){1'b0}}, pri} > eff;
    skip_eq = (pri == ent.priority_lvl) && (upd < g_rdata) && (own_ge < g_rdata);
    km1     = k - 1'b1;
    km2     = k - CNT_W'(2);
  end

  // sequencer
  always_comb begin
    state_next    = state;
    clr_idx_next  = clr_idx;
    k_next        = k;
    pos_next      = pos;
    count_next    = count;
    pri_next      = pri;
    dur_next      = dur;
    grp_next      = grp;
    own_ge_next   = own_ge;
    new_end_next  = new_end;
    ent_next      = ent;
    o_pos_next    = o_pos;
    o_end_next    = o_end;
    o_status_next = o_status;
    e_we    = 1'b0;
    e_waddr = km1[QADDR_W-1:0];
    e_wdata = ent;
    e_raddr = km1[QADDR_W-1:0];
    g_we    = 1'b0;
    g_waddr = grp;
    g_wdata = new_end;
    g_raddr = grp;
    in.ready  = 1'b0;
    out.valid = 1'b0;

    unique case (state)
      S_CLR: begin
        g_we    = 1'b1;
        g_waddr = clr_idx;
        g_wdata = '0;
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == GADDR_W'(GROUP_COUNT - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in.ready = 1'b1;
        g_raddr  = GRP_MAP[in.group_id];
        if (in.valid) begin
          pri_next = in.task_priority;
          dur_next = in.task_duration;
          grp_next = GRP_MAP[in.group_id];
          k_next   = count;
          if (count >= CNT_W'(QUEUE_DEPTH)) begin
            o_pos_next    = '0;
            o_end_next    = '0;
            o_status_next = STATUS_FULL;
            state_next    = S_OUT;
          end else begin
            state_next = S_OWN;
          end
        end
      end
      S_OWN: begin
        own_ge_next  = g_rdata;
        new_end_next = {{(TIME_W - DUR_W){1'b0}}, dur};
        pos_next     = '0;
        if (k == '0) begin
          state_next = S_FIN;
        end else begin
          state_next = S_ERD;
        end
      end
      S_ERD: begin
        ent_next   = e_rdata;
        g_raddr    = e_rdata.grp;
        state_next = S_GRD;
      end
      S_GRD: begin
        e_raddr = km2[QADDR_W-1:0];
        if (skip_hi || skip_eq) begin
          e_we    = 1'b1;
          e_wdata = '{end_time: upd, age: age_upd, priority_lvl: ent.priority_lvl,
                      grp: ent.grp};
          if (skip_hi && (upd > g_rdata)) begin
            g_we    = 1'b1;
            g_waddr = ent.grp;
            g_wdata = upd;
          end
          k_next = km1;
          if (k == CNT_W'(1)) begin
            state_next = S_FIN;
          end else begin
            state_next = S_ERD;
          end
        end else begin
          new_end_next = upd;
          pos_next     = k;
          state_next   = S_FIN;
        end
      end
      S_FIN: begin
        // own group end, then start the shift from the tail
        if (own_ge < new_end) begin
          g_we = 1'b1;
        end
        k_next  = count;
        e_raddr = QADDR_W'(count - 1'b1);
        if (count > pos) begin
          state_next = S_SWR;
        end else begin
          state_next = S_INS;
        end
      end
      S_SWR: begin
        e_we    = 1'b1;
        e_waddr = k[QADDR_W-1:0];
        e_wdata = e_rdata;
        e_raddr = km2[QADDR_W-1:0];
        k_next  = km1;
        if (km1 <= pos) begin
          state_next = S_INS;
        end
      end
      S_INS: begin
        e_we    = 1'b1;
        e_waddr = pos[QADDR_W-1:0];
        e_wdata = '{end_time: new_end, age: '0, priority_lvl: pri, grp: grp};
        count_next    = count + 1'b1;
        o_pos_next    = POS_W'(pos);
        o_end_next    = new_end;
        o_status_next = STATUS_INSERTED;
        state_next    = S_OUT;
      end
      S_OUT: begin
        out.valid = 1'b1;
        if (out.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out.insert_position = o_pos;
  assign out.task_end        = o_end;
  assign out.status          = o_status;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_idx  <= '0;
      count    <= '0;
      age_step <= STEP_W'(1);
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      count   <= count_next;
      if (age_step_we) begin
        age_step <= age_step_wdata;
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    k        <= k_next;
    pos      <= pos_next;
    pri      <= pri_next;
    dur      <= dur_next;
    grp      <= grp_next;
    own_ge   <= own_ge_next;
    new_end  <= new_end_next;
    ent      <= ent_next;
    o_pos    <= o_pos_next;
    o_end    <= o_end_next;
    o_status <= o_status_next;
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import apbi_pkg::*;

  localparam int WATCH_LIMIT = 20000;
  localparam int SETTLE = 300;

  typedef struct {
    logic [PRI_W-1:0] pri;
    logic [DUR_W-1:0] dur;
    logic [GID_W-1:0] gid;
  } job_req_t;

  typedef struct {
    logic [POS_W-1:0]  pos;
    logic [TIME_W-1:0] fin;
    logic              st;
  } placement_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic age_step_we;
  logic [STEP_W-1:0] age_step_wdata;

  apbi_in_if in_ch();
  apbi_out_if out_ch();

  aged_priority_backfill_insert_top dut (
    .clk(clk),
    .rst(rst),
    .in(in_ch.sink),
    .out(out_ch.source),
    .age_step_we(age_step_we),
    .age_step_wdata(age_step_wdata)
  );

  always #10 clk = ~clk;

  // shadow copy of the job queue
  logic [TIME_W-1:0]  q_end [QUEUE_DEPTH];
  logic [AGE_W-1:0]   q_age [QUEUE_DEPTH];
  logic [PRI_W-1:0]   q_pri [QUEUE_DEPTH];
  logic [GADDR_W-1:0] q_grp [QUEUE_DEPTH];
  logic [TIME_W-1:0]  g_end_tab [GROUP_COUNT];
  int unsigned        q_count;
  logic [STEP_W-1:0]  step_q;

  job_req_t   pend_q[$];
  placement_t placement_q[$];
  int errors = 0;
  int n_results = 0;
  int n_full = 0;
  int send_pct = 0;
  int recv_pct = 0;
  logic took;
  int quiet_cycles = 0;

  function automatic logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] t, logic [DUR_W-1:0] d);
    logic [TIME_W:0] s;
    s = {1'b0, t} + d;
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  function automatic logic [AGE_W-1:0] aged(logic [AGE_W-1:0] a);
    logic [AGE_W:0] s;
    s = {1'b0, a} + step_q;
    return s[AGE_W] ? AGE_MAX : s[AGE_W-1:0];
  endfunction

  // work out where a request lands and update the shadow queue
  function automatic placement_t place_job(job_req_t r);
    placement_t p;
    logic [GADDR_W-1:0] g, own_g;
    logic [TIME_W-1:0] own_end, new_end, upd, ge;
    int unsigned pos, eff;
    bit stopped;
    if (q_count >= QUEUE_DEPTH) begin
      p.pos = '0;
      p.fin = '0;
      p.st = STATUS_FULL;
      return p;
    end
    own_g = GADDR_W'(r.gid % GROUP_COUNT);
    own_end = g_end_tab[own_g];
    new_end = TIME_W'(r.dur);
    pos = 0;
    stopped = 0;
    for (int k = q_count; k > 0 && !stopped; k--) begin
      g = q_grp[k-1];
      ge = g_end_tab[g];
      upd = sat_add(q_end[k-1], r.dur);
      eff = q_pri[k-1] + (q_age[k-1] >> 2);
      if (r.pri > eff) begin
        q_end[k-1] = upd;
        if (upd > ge) g_end_tab[g] = upd;
        q_age[k-1] = aged(q_age[k-1]);
      end else if (r.pri == q_pri[k-1] && upd < ge && own_end < ge) begin
        q_end[k-1] = upd;
        q_age[k-1] = aged(q_age[k-1]);
      end else begin
        new_end = upd;
        pos = k;
        stopped = 1;
      end
    end
    if (own_end < new_end) g_end_tab[own_g] = new_end;
    for (int k = q_count; k > pos; k--) begin
      q_end[k] = q_end[k-1];
      q_age[k] = q_age[k-1];
      q_pri[k] = q_pri[k-1];
      q_grp[k] = q_grp[k-1];
    end
    q_end[pos] = new_end;
    q_age[pos] = '0;
    q_pri[pos] = r.pri;
    q_grp[pos] = own_g;
    q_count++;
    p.pos = POS_W'(pos);
    p.fin = new_end;
    p.st = STATUS_INSERTED;
    return p;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // request driver and result-side ready, changed on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if (!in_ch.valid || took) begin
        if (pend_q.size() > 0 && $urandom_range(99) >= send_pct) begin
          job_req_t r;
          r = pend_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.task_priority <= r.pri;
          in_ch.task_duration <= r.dur;
          in_ch.group_id <= r.gid;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_pct);
    end
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    took <= in_ch.valid && in_ch.ready;
    if (!rst) begin
      if (age_step_we) step_q = age_step_wdata;
      if (in_ch.valid && in_ch.ready) begin
        job_req_t r;
        r.pri = in_ch.task_priority;
        r.dur = in_ch.task_duration;
        r.gid = in_ch.group_id;
        placement_q.insert(placement_q.size(), place_job(r));
      end
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (placement_q.size() == 0) begin
          report("unexpected result", 64'(out_ch.insert_position), 64'(0));
        end else begin
          placement_t e;
          e = placement_q.pop_front();
          if (out_ch.status == STATUS_FULL) n_full++;
          if (out_ch.insert_position !== e.pos)
            report("insert_position", 64'(out_ch.insert_position), 64'(e.pos));
          if (out_ch.task_end !== e.fin)
            report("task_end", 64'(out_ch.task_end), 64'(e.fin));
          if (out_ch.status !== e.st) report("status", 64'(out_ch.status), 64'(e.st));
        end
      end
      // watchdog on lack of progress
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("watchdog expired at %0t", $realtime);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic add_job(int p, logic [DUR_W-1:0] d, int g);
    job_req_t r;
    r.pri = PRI_W'(p);
    r.dur = d;
    r.gid = GID_W'(g);
    pend_q.insert(pend_q.size(), r);
  endtask

  task automatic add_random(int n);
    logic [DUR_W-1:0] d;
    int p, g, sel;
    for (int i = 0; i < n; i++) begin
      p = ($urandom_range(99) < 60) ? $urandom_range(0, 4) : $urandom_range(0, 255);
      sel = $urandom_range(99);
      if (sel < 70) d = $urandom_range(0, 1000);
      else if (sel < 90) d = $urandom;
      else d = 32'hFFFF_FFFF - $urandom_range(0, 15);
      g = ($urandom_range(99) < 70) ? $urandom_range(0, 7) : $urandom_range(0, 63);
      add_job(p, d, g);
    end
  endtask

  // hold until every request has been answered and the block has gone quiet
  task automatic drain();
    while (pend_q.size() > 0 || in_ch.valid || placement_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_step(logic [STEP_W-1:0] v);
    @(negedge clk);
    age_step_we <= 1'b1;
    age_step_wdata <= v;
    @(negedge clk);
    age_step_we <= 1'b0;
  endtask

  task automatic run_phase(int n, int sp, int rp);
    send_pct = sp;
    recv_pct = rp;
    add_random(n);
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.task_priority = '0;
    in_ch.task_duration = '0;
    in_ch.group_id = '0;
    out_ch.ready = 1'b0;
    age_step_we = 1'b0;
    age_step_wdata = '0;
    took = 1'b0;
    q_count = 0;
    step_q = 8'd1;
    for (int i = 0; i < GROUP_COUNT; i++) g_end_tab[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty queue, extremes, saturation, equal-priority backfill
    add_job(0, 0, 0);
    add_job(255, 32'hFFFF_FFFF, 63);
    add_job(255, 32'hFFFF_FFFF, 63);
    add_job(0, 32'hFFFF_FFFF, 1);
    add_job(0, 32'hFFFF_FFFF, 1);
    add_job(0, 32'hFFFF_FFFF, 1);
    add_job(128, 5, 2);
    add_job(128, 3, 3);
    add_job(128, 1, 4);
    add_job(200, 1, 2);
    add_job(1, 100, 5);
    add_job(1, 10, 6);
    add_job(1, 2, 7);
    add_job(2, 0, 63);
    add_job(255, 1, 0);
    add_job(0, 1, 62);
    drain();

    write_step(8'd255);
    run_phase(16, 0, 0);
    write_step(8'd0);
    run_phase(16, 76, 0);
    write_step(8'($urandom_range(1, 254)));
    run_phase(16, 0, 76);
    write_step(8'd1);
    // queue is full from here on: every request is dropped
    run_phase(12, 21, 21);
    run_phase(430, 0, 0);
    run_phase(430, 76, 0);
    run_phase(430, 0, 76);
    run_phase(430, 21, 21);

    if (placement_q.size() > 0) report("results left over", 64'(placement_q.size()), 64'(0));
    $display("covered %0d results, %0d dropped on a full queue, %0d mismatches",
             n_results, n_full, errors);
    $display("age steps 1, 255, 0, random and 1; four idling patterns");
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
